// File: src/psa_pkg.sv
package psa_pkg;

  localparam int ReadyDepthDef = 32;
  localparam int WaitDepthDef  = 32;
  localparam int IdBitsDef     = 8;
  localparam logic [3:0] MaxPrioReset = 4'd7;

  typedef enum logic [1:0] {
    OP_ADMIT = 2'd0,
    OP_TICK  = 2'd1,
    OP_IO    = 2'd2,
    OP_EXIT  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] task_id;
    logic [3:0] task_priority;
  } sched_in_t;

  typedef struct packed {
    logic       running_valid;
    logic [7:0] running_id;
    logic [3:0] running_priority;
    logic       all_done;
    logic       overflow;
  } sched_out_t;

endpackage

// File: src/psa_wait_fifo.sv
module psa_wait_fifo #(
  parameter int WAIT_DEPTH = psa_pkg::WaitDepthDef,
  parameter int ID_BITS    = psa_pkg::IdBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [ID_BITS+3:0] push_data,
  input  logic               pop,
  output logic [ID_BITS+3:0] head_data,
  output logic               empty,
  output logic               full
);
  import psa_pkg::*;

  localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CW = $clog2(WAIT_DEPTH + 1);

  logic [ID_BITS+3:0] mem [WAIT_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(WAIT_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
    head_data <= mem[pop ? ((head == AW'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1) : head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AW'(WAIT_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == AW'(WAIT_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: src/priority_scheduler_with_aging_core.sv
// An admit goes from S_IDLE straight to S_OUT; any other event first passes S_PRE,
// the ready table scan, the shift if a task was picked and, on a tick, the wait pop.
// The scan steps S_SCANRD and S_SCAN per ready entry, the shift S_SHRD and S_SHWR.
// Throughput: one event at a time; busy stays high until after the result beat.
// The result beat is a single-cycle strobe; the receiver cannot stall it.
// Reset is synchronous and active high; it empties both tables and idles the core.
module priority_scheduler_with_aging_core #(
  parameter int READY_DEPTH = psa_pkg::ReadyDepthDef,
  parameter int WAIT_DEPTH  = psa_pkg::WaitDepthDef,
  parameter int ID_BITS     = psa_pkg::IdBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  psa_pkg::sched_in_t  in_beat,
  output logic                busy,
  output logic                done,
  output psa_pkg::sched_out_t out_beat,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_data
);
  import psa_pkg::*;

  localparam int AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int CW = $clog2(READY_DEPTH + 1);
  localparam int EW = ID_BITS + 4;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PRE    = 11'b00000000010,
    S_SCANRD = 11'b00000000100,
    S_SCAN   = 11'b00000001000,
    S_SHRD   = 11'b00000010000,
    S_SHWR   = 11'b00000100000,
    S_WPOP   = 11'b00001000000,
    S_WWAIT  = 11'b00010000000,
    S_WINS   = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_TAIL   = 11'b10000000000
  } state_t;

  state_t state;
  logic [3:0] max_prio;
  op_t op;
  logic [EW-1:0] mem [READY_DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] best;
  logic [3:0]    best_prio;
  logic [ID_BITS-1:0] best_id;
  logic          run_valid;
  logic [ID_BITS-1:0] run_id;
  logic [3:0]    run_prio;
  logic          ovf;
  logic          fin;
  logic          w_push, w_pop, w_empty, w_full;
  logic [EW-1:0] w_head;
  logic [3:0]    clamp;

  assign busy = (state != S_IDLE);
  assign clamp = (in_beat.task_priority > max_prio) ? max_prio : in_beat.task_priority;

  psa_wait_fifo #(.WAIT_DEPTH(WAIT_DEPTH), .ID_BITS(ID_BITS)) u_wait (
    .clk, .rst, .push(w_push), .push_data({run_id, run_prio}), .pop(w_pop),
    .head_data(w_head), .empty(w_empty), .full(w_full)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = {run_id, run_prio};
    w_push  = 1'b0;
    w_pop   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start && op_t'(in_beat.operation) == OP_ADMIT && count != CW'(READY_DEPTH)) begin
          wr_en   = 1'b1;
          wr_data = {in_beat.task_id[ID_BITS-1:0], clamp};
        end
      end
      S_PRE: begin
        if (run_valid && op == OP_TICK && count != CW'(READY_DEPTH)) begin
          wr_en = 1'b1;
        end
        if (run_valid && op == OP_IO && !w_full) begin
          w_push = 1'b1;
        end
      end
      S_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx - 1'b1);
        wr_data = rd_data;
      end
      S_WINS: begin
        wr_en   = (count != CW'(READY_DEPTH));
        wr_data = w_head;
        w_pop   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      max_prio  <= MaxPrioReset;
      count     <= '0;
      run_valid <= 1'b0;
      run_id    <= '0;
      run_prio  <= '0;
      done      <= 1'b0;
      ovf       <= 1'b0;
      fin       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        max_prio <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op  <= op_t'(in_beat.operation);
            ovf <= 1'b0;
            fin <= 1'b0;
            if (op_t'(in_beat.operation) == OP_ADMIT) begin
              if (count == CW'(READY_DEPTH)) begin
                ovf <= 1'b1;
              end else begin
                count <= count + 1'b1;
              end
              state <= S_OUT;
            end else begin
              if (op_t'(in_beat.operation) == OP_TICK && run_valid
                  && run_prio < max_prio) begin
                run_prio <= run_prio + 1'b1;
              end
              state <= S_PRE;
            end
          end
        end
        S_PRE: begin
          if (run_valid && op == OP_TICK) begin
            if (count == CW'(READY_DEPTH)) begin
              ovf <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
          end
          if (run_valid && op == OP_IO && w_full) begin
            ovf <= 1'b1;
          end
          idx       <= '0;
          best      <= '0;
          best_prio <= '1;
          state     <= S_SCANRD;
        end
        S_SCANRD: begin
          if (idx == count) begin
            if (count == '0) begin
              run_valid <= 1'b0;
              run_id    <= '0;
              run_prio  <= '0;
              fin       <= (op == OP_EXIT);
              state     <= (op == OP_TICK) ? S_WPOP : S_OUT;
            end else begin
              run_valid <= 1'b1;
              run_id    <= best_id;
              run_prio  <= best_prio;
              idx       <= best + 1'b1;
              state     <= S_SHRD;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == '0 || rd_data[3:0] < best_prio) begin
            best      <= idx;
            best_prio <= rd_data[3:0];
            best_id   <= rd_data[EW-1:4];
          end
          idx   <= idx + 1'b1;
          state <= S_SCANRD;
        end
        S_SHRD: begin
          if (idx == count) begin
            count <= count - 1'b1;
            state <= (op == OP_TICK) ? S_WPOP : S_OUT;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx   <= idx + 1'b1;
          state <= S_SHRD;
        end
        S_WPOP: state <= w_empty ? S_OUT : S_WWAIT;
        S_WWAIT: state <= S_WINS;
        S_WINS: begin
          if (count == CW'(READY_DEPTH)) begin
            ovf <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_TAIL;
        end
        S_TAIL: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_beat.running_valid    = run_valid;
    out_beat.running_id       = run_valid ? 8'(run_id) : '0;
    out_beat.running_priority = run_valid ? run_prio : '0;
    out_beat.all_done         = fin;
    out_beat.overflow         = ovf;
  end

endmodule

// File: tb/priority_scheduler_with_aging_core_test.sv
module priority_scheduler_with_aging_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psa_pkg::*;

  localparam int ReadyCap = 32;
  localparam int WaitCap = 32;
  localparam int CycleLimit = 2000000;

  typedef enum logic [1:0] {
    JOB_EVENT,
    JOB_SET_CEILING,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t kind;
    sched_in_t beat;
    logic [3:0] ceiling;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  sched_in_t in_beat = '0;
  logic busy;
  logic done;
  sched_out_t out_beat;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;

  job_t jobs[$];
  sched_out_t sched_expected[$];

  logic [3:0] model_ceiling;
  logic [7:0] ready_id[ReadyCap];
  logic [3:0] ready_pr[ReadyCap];
  int ready_n;
  logic [7:0] park_id[$];
  logic [3:0] park_pr[$];
  logic run_on;
  logic [7:0] run_id;
  logic [3:0] run_pr;
  logic dropped;

  int gap;
  int settle;
  int cycles;
  int errors;
  int events_sent;
  int results_seen;
  int overflow_seen;
  int all_done_seen;

  priority_scheduler_with_aging_core i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .in_beat(in_beat),
    .busy(busy),
    .done(done),
    .out_beat(out_beat),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void ready_join(logic [7:0] id, logic [3:0] pr);
    if (ready_n >= ReadyCap) begin
      dropped = 1'b1;
    end else begin
      ready_id[ready_n] = id;
      ready_pr[ready_n] = pr;
      ready_n++;
    end
  endfunction

  function automatic bit pick_best();
    int best;
    best = 0;
    if (ready_n == 0) begin
      run_on = 1'b0;
      run_id = '0;
      run_pr = '0;
      return 1'b0;
    end
    for (int i = 1; i < ready_n; i++) begin
      if (ready_pr[i] < ready_pr[best]) best = i;
    end
    run_on = 1'b1;
    run_id = ready_id[best];
    run_pr = ready_pr[best];
    for (int i = best; i + 1 < ready_n; i++) begin
      ready_id[i] = ready_id[i + 1];
      ready_pr[i] = ready_pr[i + 1];
    end
    ready_n--;
    return 1'b1;
  endfunction

  function automatic sched_out_t schedule_event(sched_in_t ev);
    sched_out_t r;
    logic [3:0] pr;
    bit idle_exit;
    idle_exit = 1'b0;
    dropped = 1'b0;
    pr = ev.task_priority;
    case (op_t'(ev.operation))
      OP_ADMIT: begin
        if (pr > model_ceiling) pr = model_ceiling;
        ready_join(ev.task_id, pr);
      end
      OP_TICK: begin
        if (run_on) begin
          if (run_pr < model_ceiling) run_pr = run_pr + 4'd1;
          ready_join(run_id, run_pr);
        end
        void'(pick_best());
        if (park_id.size() > 0) begin
          ready_join(park_id.pop_front(), park_pr.pop_front());
        end
      end
      OP_IO: begin
        if (run_on) begin
          if (park_id.size() >= WaitCap) begin
            dropped = 1'b1;
          end else begin
            park_id.push_back(run_id);
            park_pr.push_back(run_pr);
          end
        end
        void'(pick_best());
      end
      default: begin
        if (!pick_best()) idle_exit = 1'b1;
      end
    endcase
    r.running_valid = run_on;
    r.running_id = run_on ? run_id : 8'd0;
    r.running_priority = run_on ? run_pr : 4'd0;
    r.all_done = idle_exit;
    r.overflow = dropped;
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    logic we_next;
    logic start_next;
    we_next = 1'b0;
    start_next = start;
    if (rst) begin
      start_next = 1'b0;
      gap = 0;
      settle = 12;
    end else if (start) begin
      if (!busy) begin
        sched_expected.push_back(schedule_event(in_beat));
        events_sent++;
        start_next = 1'b0;
        gap = pick_gap();
      end
    end else if (gap > 0) begin
      gap--;
    end else if (jobs.size() > 0) begin
      case (jobs[0].kind)
        JOB_EVENT: begin
          if (!busy) begin
            in_beat <= jobs[0].beat;
            start_next = 1'b1;
            void'(jobs.pop_front());
          end
        end
        JOB_SET_CEILING: begin
          if (sched_expected.size() == 0 && !busy) begin
            if (settle > 0) begin
              settle--;
            end else begin
              we_next = 1'b1;
              cfg_data <= jobs[0].ceiling;
              model_ceiling = jobs[0].ceiling;
              void'(jobs.pop_front());
              settle = 12;
            end
          end
        end
        default: begin
          if (sched_expected.size() == 0) void'(jobs.pop_front());
        end
      endcase
    end
    cfg_we <= we_next;
    start <= start_next;
  end

  always @(posedge clk) begin
    sched_out_t want;
    if (!rst && done) begin
      results_seen++;
      if (out_beat.overflow === 1'b1) overflow_seen++;
      if (out_beat.all_done === 1'b1) all_done_seen++;
      if (sched_expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_beat);
      end else begin
        want = sched_expected.pop_front();
        if (out_beat.running_valid !== want.running_valid ||
            out_beat.running_id !== want.running_id ||
            out_beat.running_priority !== want.running_priority ||
            out_beat.all_done !== want.all_done ||
            out_beat.overflow !== want.overflow) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected v=%0d id=%0d pr=%0d done=%0d ovf=%0d",
                     want.running_valid, want.running_id, want.running_priority,
                     want.all_done, want.overflow);
            $display("          actual   v=%0d id=%0d pr=%0d done=%0d ovf=%0d",
                     out_beat.running_valid, out_beat.running_id,
                     out_beat.running_priority, out_beat.all_done, out_beat.overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void add_event(op_t op, logic [7:0] id, logic [3:0] pr);
    job_t j;
    j.kind = JOB_EVENT;
    j.beat.operation = op;
    j.beat.task_id = id;
    j.beat.task_priority = pr;
    j.ceiling = '0;
    jobs.push_back(j);
  endfunction

  function automatic void add_ceiling(logic [3:0] v);
    job_t j;
    j.kind = JOB_SET_CEILING;
    j.beat = '0;
    j.ceiling = v;
    jobs.push_back(j);
  endfunction

  function automatic void add_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.beat = '0;
    j.ceiling = '0;
    jobs.push_back(j);
  endfunction

  function automatic void add_random(int n, int w_admit, int w_tick, int w_io);
    int k;
    op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < w_admit) op = OP_ADMIT;
      else if (k < w_admit + w_tick) op = OP_TICK;
      else if (k < w_admit + w_tick + w_io) op = OP_IO;
      else op = OP_EXIT;
      add_event(op, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    end
  endfunction

  initial begin
    logic [3:0] ceilings[6];
    model_ceiling = MaxPrioReset;
    ready_n = 0;
    run_on = 1'b0;
    run_id = '0;
    run_pr = '0;
    cycles = 0;
    errors = 0;
    events_sent = 0;
    results_seen = 0;
    overflow_seen = 0;
    all_done_seen = 0;

    add_event(OP_EXIT, 8'd0, 4'd0);
    add_event(OP_TICK, 8'd0, 4'd0);
    add_event(OP_IO, 8'd0, 4'd0);
    add_event(OP_ADMIT, 8'd255, 4'd15);
    add_event(OP_ADMIT, 8'd0, 4'd0);
    add_event(OP_ADMIT, 8'd170, 4'd7);
    add_event(OP_ADMIT, 8'd85, 4'd7);
    add_event(OP_TICK, 8'd0, 4'd0);
    add_event(OP_TICK, 8'd0, 4'd0);
    add_event(OP_IO, 8'd0, 4'd0);
    add_event(OP_TICK, 8'd0, 4'd0);
    add_event(OP_IO, 8'd0, 4'd0);
    add_event(OP_EXIT, 8'd0, 4'd0);
    add_event(OP_TICK, 8'd0, 4'd0);
    add_event(OP_EXIT, 8'd0, 4'd0);
    add_event(OP_EXIT, 8'd0, 4'd0);
    add_event(OP_EXIT, 8'd0, 4'd0);
    add_event(OP_EXIT, 8'd0, 4'd0);
    add_event(OP_EXIT, 8'd0, 4'd0);

    ceilings = '{4'd15, 4'd0, 4'd3, 4'd7, 4'd15, 4'd0};
    ceilings[3] = 4'($urandom_range(1, 14));
    for (int p = 0; p < 6; p++) begin
      add_ceiling(ceilings[p]);
      add_random(90, 35, 35, 15);
      if (p == 2) add_drain();
      add_random(30, 20, 20, 10);
    end
    // Fill the ready table past its depth, then park enough tasks to overflow the wait queue.
    add_ceiling(4'd15);
    for (int i = 0; i < 36; i++) add_event(OP_ADMIT, 8'($urandom_range(0, 255)),
                                           4'($urandom_range(0, 15)));
    for (int i = 0; i < 36; i++) add_event(OP_IO, 8'($urandom_range(0, 255)),
                                           4'($urandom_range(0, 15)));
    add_random(40, 0, 60, 10);
    add_random(40, 30, 30, 20);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (jobs.size() > 0 || start || sched_expected.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d events over several priority ceilings; %0d results checked.",
             events_sent, results_seen);
    $display("Results with overflow: %0d, with all tasks done: %0d, mismatches: %0d.",
             overflow_seen, all_done_seen, errors);
    if (errors == 0 && sched_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
